// ===== rtl/psm_pkg.sv =====
package psm_pkg;

  localparam int SLOT_W  = 4;
  localparam int TIME_W  = 63;
  localparam int WIN_W   = 32;
  localparam int LIMIT_W = 8;
  localparam int TOTAL_W = 32;
  localparam int CODE_W  = 2;
  localparam int MASK_W  = 16;
  localparam int MISS_W  = 8;

  localparam int APB_AW       = 5;
  localparam int APB_DW       = 64;
  localparam int REG_ADDR_LSB = 3;

  localparam logic [1:0] REG_SYNC_WINDOW   = 2'd0;
  localparam logic [1:0] REG_BAD_LIMIT     = 2'd1;
  localparam logic [1:0] REG_STALE_TIMEOUT = 2'd2;

  localparam logic [CODE_W-1:0] SYNC_UNKNOWN = 2'd0;
  localparam logic [CODE_W-1:0] SYNC_GOOD    = 2'd1;
  localparam logic [CODE_W-1:0] SYNC_LOST    = 2'd2;

  localparam logic [WIN_W-1:0]   SYNC_WINDOW_RST   = 32'd30000;
  localparam logic [LIMIT_W-1:0] BAD_LIMIT_RST     = 8'd20;
  localparam logic [TIME_W-1:0]  STALE_TIMEOUT_RST = 63'd120000000000;

  localparam logic [MISS_W-1:0]  MISS_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] stamp;
    logic              is_pulser;
    logic              first_of_event;
    logic              last_of_event;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  out_slot;
    logic [CODE_W-1:0]  sync_code;
    logic [TOTAL_W-1:0] total_events;
    logic               sync_reset;
    logic [MASK_W-1:0]  stale_mask;
  } out_t;

  typedef struct packed {
    logic carry;
    logic zero;
    logic lt;
  } alu_flags_t;

endpackage

// ===== rtl/pulser_sync_monitor_core.sv =====
// Pulser sync monitor. A record is taken when start is high and busy is low; busy then stays
// high until the single result has been produced, and the result appears on out_data for
// exactly one cycle with out_strobe high. The receiver cannot stall it, so it must take every
// transfer as it comes. All per-slot work runs through one shared 64-bit add-and-compare unit,
// slot by slot: a record passes through a self step and an output step, plus a pair
// comparison pass over all slots when it is a pulser from a slot that has pulsed before, plus a
// stale check over all slots, which also makes the timeout sweep when it closes an event.
// After reset the block stays busy while it clears its memories; configuration writes are
// taken throughout.
module pulser_sync_monitor_core #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  psm_pkg::in_t                in_data,
  output logic                        out_strobe,
  output psm_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psm_pkg::APB_AW-1:0]  paddr,
  input  logic [psm_pkg::APB_DW-1:0]  pwdata,
  output logic [psm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int IW    = $clog2(SLOTS);
  localparam int PAIRS = SLOTS * SLOTS;
  localparam int PW    = $clog2(PAIRS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SELF = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
  localparam logic [PW-1:0] LAST_PAIR = PW'(PAIRS - 1);

  // Configuration registers
  logic [psm_pkg::WIN_W-1:0]   win_r;
  logic [psm_pkg::LIMIT_W-1:0] limit_r;
  logic [psm_pkg::TIME_W-1:0]  timeout_r;
  logic [1:0]                  reg_sel;
  logic                        cfg_wr;

  // Sequencer
  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic          phase_r, phase_nxt;

  // Item context
  psm_pkg::in_t                item_r;
  logic                        in_range_r;
  logic [psm_pkg::TIME_W-1:0]  cur_time_r, cur_time_nxt;
  logic [psm_pkg::CODE_W-1:0]  me_state_r, me_state_nxt;
  logic                        cleared_r, cleared_nxt;
  logic [psm_pkg::MASK_W-1:0]  mask_r, mask_nxt;
  logic [psm_pkg::CODE_W-1:0]  sync_state_r [SLOTS];
  logic [psm_pkg::CODE_W-1:0]  sync_state_nxt [SLOTS];

  // Memories and their registered read data
  logic [psm_pkg::TIME_W-1:0]  pt_mem [SLOTS];
  logic [psm_pkg::TIME_W-1:0]  ls_mem [SLOTS];
  logic [psm_pkg::TOTAL_W-1:0] et_mem [SLOTS];
  logic [psm_pkg::MISS_W-1:0]  pm_mem [PAIRS];
  logic [psm_pkg::TIME_W-1:0]  pt_rd_r;
  logic [psm_pkg::TIME_W-1:0]  ls_rd_r;
  logic [psm_pkg::TOTAL_W-1:0] et_rd_r;
  logic [psm_pkg::MISS_W-1:0]  pm_rd_r;
  logic [PW-1:0]               pm_addr_r;
  logic [PW-1:0]               pm_raddr;

  logic                        pt_we, ls_we, et_we, pm_we;
  logic [IW-1:0]               pt_waddr, ls_waddr, et_waddr;
  logic [PW-1:0]               pm_waddr;
  logic [psm_pkg::TIME_W-1:0]  pt_wdata, ls_wdata;
  logic [psm_pkg::TOTAL_W-1:0] et_wdata;
  logic [psm_pkg::MISS_W-1:0]  pm_wdata;

  // Shared unit
  logic [psm_pkg::TIME_W-1:0]  alu_a, alu_b;
  logic                        alu_sub;
  logic [psm_pkg::TIME_W:0]    alu_limit;
  psm_pkg::alu_flags_t         flags;

  logic                        accept;
  logic                        in_range_in;
  logic [IW-1:0]               in_idx;
  logic [IW-1:0]               me_idx;
  logic [IW-1:0]               pair_lo;
  logic                        clr_slot;
  logic                        take;
  logic [psm_pkg::MISS_W-1:0]  miss_inc;
  logic                        miss_bad;

  logic                        out_strobe_r;
  psm_pkg::out_t               out_data_r;

  assign accept      = start && !busy;
  assign busy        = (state_r != S_IDLE);
  assign in_idx      = IW'(in_data.slot);
  assign me_idx      = IW'(item_r.slot);
  assign in_range_in = (32'(in_data.slot) < 32'(SLOTS));
  assign clr_slot    = (32'(clr_r) < 32'(SLOTS));

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[psm_pkg::APB_AW-1:psm_pkg::REG_ADDR_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      psm_pkg::REG_SYNC_WINDOW:   prdata = psm_pkg::APB_DW'(win_r);
      psm_pkg::REG_BAD_LIMIT:     prdata = psm_pkg::APB_DW'(limit_r);
      psm_pkg::REG_STALE_TIMEOUT: prdata = psm_pkg::APB_DW'(timeout_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= psm_pkg::SYNC_WINDOW_RST;
      limit_r   <= psm_pkg::BAD_LIMIT_RST;
      timeout_r <= psm_pkg::STALE_TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        psm_pkg::REG_SYNC_WINDOW:   win_r     <= pwdata[psm_pkg::WIN_W-1:0];
        psm_pkg::REG_BAD_LIMIT:     limit_r   <= pwdata[psm_pkg::LIMIT_W-1:0];
        psm_pkg::REG_STALE_TIMEOUT: timeout_r <= pwdata[psm_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared add-and-compare unit
  always_comb begin
    if (state_r == S_WALK) begin
      alu_a     = item_r.stamp;
      alu_b     = pt_rd_r;
      alu_sub   = 1'b1;
      alu_limit = (psm_pkg::TIME_W + 1)'(win_r);
    end else if (!phase_r) begin
      alu_a     = pt_rd_r;
      alu_b     = timeout_r;
      alu_sub   = 1'b0;
      alu_limit = {1'b0, cur_time_r};
    end else begin
      alu_a     = ls_rd_r;
      alu_b     = timeout_r;
      alu_sub   = 1'b0;
      alu_limit = {1'b0, cur_time_r};
    end
  end

  psm_alu u_alu (
    .opa   (alu_a),
    .opb   (alu_b),
    .sub   (alu_sub),
    .limit (alu_limit),
    .flags (flags)
  );

  assign take     = (idx_r != me_idx) && (pt_rd_r != '0) && flags.carry && !flags.zero;
  assign miss_inc = (pm_rd_r == psm_pkg::MISS_MAX) ? psm_pkg::MISS_MAX : pm_rd_r + 1'b1;
  assign miss_bad = (miss_inc > limit_r);

  assign pair_lo  = (idx_nxt < me_idx) ? idx_nxt : me_idx;
  assign pm_raddr = PW'(pair_lo) * PW'(SLOTS) + PW'((idx_nxt < me_idx) ? me_idx : idx_nxt);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    clr_nxt      = clr_r;
    phase_nxt    = phase_r;
    cur_time_nxt = cur_time_r;
    me_state_nxt = me_state_r;
    cleared_nxt  = cleared_r;
    mask_nxt     = mask_r;
    for (int i = 0; i < SLOTS; i++) begin
      sync_state_nxt[i] = sync_state_r[i];
    end

    pt_we    = 1'b0;
    pt_waddr = idx_r;
    pt_wdata = '0;
    ls_we    = 1'b0;
    ls_waddr = in_idx;
    et_we    = 1'b0;
    et_waddr = idx_r;
    et_wdata = et_rd_r + 1'b1;
    pm_we    = 1'b0;
    pm_waddr = pm_addr_r;
    pm_wdata = '0;

    case (state_r)
      S_CLR: begin
        clr_nxt  = clr_r + 1'b1;
        pm_we    = 1'b1;
        pm_waddr = clr_r;
        pt_we    = clr_slot;
        pt_waddr = clr_r[IW-1:0];
        et_we    = clr_slot;
        et_waddr = clr_r[IW-1:0];
        et_wdata = '0;
        if (clr_r == LAST_PAIR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt   = S_SELF;
          idx_nxt     = in_idx;
          cleared_nxt = 1'b0;
          mask_nxt    = '0;
          if (in_data.first_of_event) begin
            cur_time_nxt = in_data.stamp;
          end
          pt_we    = in_range_in && in_data.is_pulser;
          pt_waddr = in_idx;
          pt_wdata = in_data.stamp;
        end
      end
      S_SELF: begin
        me_state_nxt = in_range_r ? sync_state_r[idx_r] : psm_pkg::SYNC_UNKNOWN;
        idx_nxt      = '0;
        phase_nxt    = !item_r.last_of_event;
        et_we        = in_range_r && !item_r.is_pulser && (et_rd_r != psm_pkg::TOTAL_MAX);
        if (in_range_r && item_r.is_pulser && (pt_rd_r != '0)) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WALK: begin
        if (take) begin
          pm_we = 1'b1;
          if (flags.lt) begin
            pm_wdata              = '0;
            sync_state_nxt[idx_r] = psm_pkg::SYNC_GOOD;
            me_state_nxt          = psm_pkg::SYNC_GOOD;
          end else begin
            pm_wdata = miss_inc;
            if (miss_bad && (sync_state_r[idx_r] != psm_pkg::SYNC_GOOD)) begin
              sync_state_nxt[idx_r] = psm_pkg::SYNC_LOST;
            end
            if (miss_bad && (me_state_r != psm_pkg::SYNC_GOOD)) begin
              me_state_nxt = psm_pkg::SYNC_LOST;
            end
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt              = S_FIN;
          idx_nxt                = '0;
          phase_nxt              = !item_r.last_of_event;
          sync_state_nxt[me_idx] = me_state_nxt;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
          if ((pt_rd_r != '0) && flags.lt) begin
            pt_we       = 1'b1;
            cleared_nxt = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
              sync_state_nxt[i] = psm_pkg::SYNC_UNKNOWN;
            end
          end
        end else begin
          if (flags.lt) begin
            mask_nxt = mask_r | (psm_pkg::MASK_W'(1) << idx_r);
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_OUT;
            idx_nxt   = me_idx;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            phase_nxt = !item_r.last_of_event;
          end
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ls_we    = accept && in_range_in;
    ls_wdata = cur_time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      idx_r        <= '0;
      clr_r        <= '0;
      phase_r      <= 1'b0;
      cur_time_r   <= '0;
      me_state_r   <= psm_pkg::SYNC_UNKNOWN;
      cleared_r    <= 1'b0;
      mask_r       <= '0;
      in_range_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        sync_state_r[i] <= psm_pkg::SYNC_UNKNOWN;
      end
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      clr_r        <= clr_nxt;
      phase_r      <= phase_nxt;
      cur_time_r   <= cur_time_nxt;
      me_state_r   <= me_state_nxt;
      cleared_r    <= cleared_nxt;
      mask_r       <= mask_nxt;
      out_strobe_r <= (state_r == S_OUT);
      if (accept) begin
        in_range_r <= in_range_in;
      end
      for (int i = 0; i < SLOTS; i++) begin
        sync_state_r[i] <= sync_state_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    pm_addr_r <= pm_raddr;
    if (state_r == S_OUT) begin
      out_data_r.out_slot     <= item_r.slot;
      out_data_r.sync_code    <= in_range_r ? sync_state_r[idx_r] : psm_pkg::SYNC_UNKNOWN;
      out_data_r.total_events <= in_range_r ? et_rd_r : '0;
      out_data_r.sync_reset   <= cleared_r;
      out_data_r.stale_mask   <= mask_r;
    end
  end

  // Per-slot memories, one write and one read port each
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rd_r <= pt_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (ls_we || (state_r == S_CLR && clr_slot)) begin
      ls_mem[(state_r == S_CLR) ? clr_r[IW-1:0] : ls_waddr] <=
        (state_r == S_CLR) ? '0 : ls_wdata;
    end
    ls_rd_r <= ls_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (et_we) begin
      et_mem[et_waddr] <= et_wdata;
    end
    et_rd_r <= et_mem[idx_nxt];
  end

  // Pair miss counts, indexed by lower slot times SLOTS plus higher slot
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
    pm_rd_r <= pm_mem[pm_raddr];
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_strobe_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_OUT))
    else $error("result strobe without a finished record");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted record did not make the block busy");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (32'(out_data.out_slot) >= 32'(SLOTS))) |->
      ((out_data.total_events == '0) && (out_data.sync_code == psm_pkg::SYNC_UNKNOWN)))
    else $error("slot outside the table reported non-zero state");

  a_walk_pulser: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (item_r.is_pulser && in_range_r))
    else $error("pair comparison pass entered for a record that is not a pulser");

endmodule

// ===== rtl/psm_alu.sv =====
module psm_alu (
  input  logic [psm_pkg::TIME_W-1:0] opa,
  input  logic [psm_pkg::TIME_W-1:0] opb,
  input  logic                       sub,
  input  logic [psm_pkg::TIME_W:0]   limit,
  output psm_pkg::alu_flags_t        flags
);

  localparam int W = psm_pkg::TIME_W + 1;

  logic [W-1:0] a_ext;
  logic [W-1:0] b_ext;
  logic [W-1:0] b_op;
  logic [W:0]   sum;

  assign a_ext = {1'b0, opa};
  assign b_ext = {1'b0, opb};
  assign b_op  = sub ? ~b_ext : b_ext;
  assign sum   = {1'b0, a_ext} + {1'b0, b_op} + {{W{1'b0}}, sub};

  assign flags.carry = sum[W];
  assign flags.zero  = (sum[W-1:0] == '0);
  assign flags.lt    = (sum[W-1:0] < limit);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int NUM_SLOTS = 16;
  localparam int IDLE_TAIL = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [psm_pkg::TIME_W-1:0] TIME_MAX = '1;

  // Tracks the monitor's per-slot state and holds the status words still to come.
  class sync_status_board;
    logic [psm_pkg::WIN_W-1:0]   window;
    logic [psm_pkg::LIMIT_W-1:0] limit;
    logic [psm_pkg::TIME_W-1:0]  timeout;
    logic [psm_pkg::TIME_W-1:0]  pulse_at [NUM_SLOTS];
    logic [psm_pkg::TIME_W-1:0]  seen_at [NUM_SLOTS];
    logic [psm_pkg::CODE_W-1:0]  code [NUM_SLOTS];
    logic [psm_pkg::MISS_W-1:0]  misses [NUM_SLOTS][NUM_SLOTS];
    logic [psm_pkg::TOTAL_W-1:0] total [NUM_SLOTS];
    logic [psm_pkg::TIME_W-1:0]  event_ns;
    psm_pkg::out_t               status_due [$];
    int                          errors;

    function void clear();
      window = psm_pkg::SYNC_WINDOW_RST;
      limit = psm_pkg::BAD_LIMIT_RST;
      timeout = psm_pkg::STALE_TIMEOUT_RST;
      event_ns = '0;
      errors = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pulse_at[i] = '0;
        seen_at[i] = '0;
        code[i] = psm_pkg::SYNC_UNKNOWN;
        total[i] = '0;
        for (int j = 0; j < NUM_SLOTS; j++) misses[i][j] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        psm_pkg::REG_SYNC_WINDOW: window = value[psm_pkg::WIN_W-1:0];
        psm_pkg::REG_BAD_LIMIT: limit = value[psm_pkg::LIMIT_W-1:0];
        psm_pkg::REG_STALE_TIMEOUT: timeout = value[psm_pkg::TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_record(psm_pkg::in_t rec);
      int            s;
      int            lo;
      int            hi;
      logic [63:0]   gap;
      logic [63:0]   lhs;
      logic [63:0]   rhs;
      bit            swept;
      psm_pkg::out_t res;
      s = int'(rec.slot);
      swept = 1'b0;
      res = '0;
      if (rec.first_of_event) event_ns = rec.stamp;
      seen_at[s] = event_ns;
      if (rec.is_pulser) begin
        if (pulse_at[s] != '0) begin
          for (int o = 0; o < NUM_SLOTS; o++) begin
            if (o != s && pulse_at[o] != '0 && rec.stamp > pulse_at[o]) begin
              lo = (o < s) ? o : s;
              hi = (o < s) ? s : o;
              gap = 64'(rec.stamp) - 64'(pulse_at[o]);
              if (gap < 64'(window)) begin
                misses[lo][hi] = '0;
                code[o] = psm_pkg::SYNC_GOOD;
                code[s] = psm_pkg::SYNC_GOOD;
              end else begin
                if (misses[lo][hi] != psm_pkg::MISS_MAX) misses[lo][hi] = misses[lo][hi] + 1'b1;
                if (misses[lo][hi] > limit) begin
                  if (code[o] != psm_pkg::SYNC_GOOD) code[o] = psm_pkg::SYNC_LOST;
                  if (code[s] != psm_pkg::SYNC_GOOD) code[s] = psm_pkg::SYNC_LOST;
                end
              end
            end
          end
        end
        pulse_at[s] = rec.stamp;
      end else if (total[s] != psm_pkg::TOTAL_MAX) begin
        total[s] = total[s] + 1'b1;
      end
      rhs = 64'(event_ns);
      if (rec.last_of_event) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          lhs = 64'(pulse_at[i]) + 64'(timeout);
          if (pulse_at[i] != '0 && lhs < rhs) begin
            for (int j = 0; j < NUM_SLOTS; j++) code[j] = psm_pkg::SYNC_UNKNOWN;
            pulse_at[i] = '0;
            swept = 1'b1;
          end
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        lhs = 64'(seen_at[i]) + 64'(timeout);
        if (lhs < rhs) res.stale_mask[i] = 1'b1;
      end
      res.out_slot = rec.slot;
      res.sync_code = code[s];
      res.total_events = total[s];
      res.sync_reset = swept;
      status_due.push_back(res);
    endfunction

    function void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void match_status(psm_pkg::out_t got);
      psm_pkg::out_t want;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected status transfer expected none, got 0x%0h", $time, got);
        errors++;
      end else begin
        want = status_due.pop_front();
        check_field("out_slot", 64'(want.out_slot), 64'(got.out_slot));
        check_field("sync_code", 64'(want.sync_code), 64'(got.sync_code));
        check_field("total_events", 64'(want.total_events), 64'(got.total_events));
        check_field("sync_reset", 64'(want.sync_reset), 64'(got.sync_reset));
        check_field("stale_mask", 64'(want.stale_mask), 64'(got.stale_mask));
      end
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  psm_pkg::in_t                  in_data;
  logic                          out_strobe;
  psm_pkg::out_t                 out_data;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [psm_pkg::APB_AW-1:0]    paddr;
  logic [psm_pkg::APB_DW-1:0]    pwdata;
  logic [psm_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  sync_status_board              sb;
  int                            cycles = 0;
  int                            burst_left;
  bit                            holding;
  logic [psm_pkg::TIME_W-1:0]    clock_ns;

  pulser_sync_monitor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1 && sb != null) sb.match_status(out_data);
  end

  function automatic psm_pkg::in_t mk(int slot, logic [63:0] stamp, bit pulser, bit first,
                                      bit last);
    psm_pkg::in_t r;
    r.slot = slot[psm_pkg::SLOT_W-1:0];
    r.stamp = stamp[psm_pkg::TIME_W-1:0];
    r.is_pulser = pulser;
    r.first_of_event = first;
    r.last_of_event = last;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= psm_pkg::APB_AW'(idx) << psm_pkg::REG_ADDR_LSB;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(psm_pkg::in_t rec);
    start <= 1'b1;
    in_data <= rec;
    holding = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.take_record(rec);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      holding = 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 120)) :
                                                 int'($urandom_range(1, 12));
    end
  endtask

  task automatic drain_results();
    if (holding) begin
      start <= 1'b0;
      holding = 1'b0;
    end
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic advance_clock();
    logic [63:0] step;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: step = 64'($urandom_range(1, 100000));
      5, 6: step = 64'($urandom_range(1, 50000000));
      7: step = 64'($urandom) << 6;
      8: step = (sb.timeout < 63'h1000_0000_0000_0000) ?
                64'(sb.timeout) + 64'($urandom_range(0, 3)) : 64'd1;
      default: step = '0;
    endcase
    clock_ns = clock_ns + step[psm_pkg::TIME_W-1:0];
    if (clock_ns > 63'h4000_0000_0000_0000) clock_ns = 63'($urandom);
  endtask

  task automatic run_phase(int n);
    int           done;
    int           cnt;
    bit           pulse_ev;
    bit           broken;
    bit           paused;
    logic [63:0]  w;
    logic [63:0]  jitter;
    psm_pkg::in_t r;
    done = 0;
    paused = 1'b0;
    while (done < n) begin
      if (!paused && done >= n / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) begin
        w = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) w = '0;
        r = mk(int'($urandom_range(0, 15)), w, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_item(r);
        done++;
      end else begin
        advance_clock();
        cnt = int'($urandom_range(1, 6));
        pulse_ev = 1'($urandom_range(0, 1));
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < cnt; i++) begin
          r.slot = psm_pkg::SLOT_W'($urandom_range(0, 15));
          r.is_pulser = pulse_ev ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0);
          if (i == 0) jitter = '0;
          else if (!r.is_pulser) jitter = 64'($urandom_range(0, 1000));
          else begin
            case ($urandom_range(0, 3))
              0: jitter = 64'($urandom_range(0, 3));
              1: jitter = 64'($urandom_range(0, 40000));
              2: jitter = 64'($urandom_range(25000, 35000));
              default: jitter = 64'($urandom) << 2;
            endcase
          end
          r.stamp = clock_ns + jitter[psm_pkg::TIME_W-1:0];
          r.first_of_event = broken ? 1'($urandom_range(0, 1)) : (i == 0);
          r.last_of_event = broken ? 1'($urandom_range(0, 1)) : (i == cnt - 1);
          send_item(r);
          done++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    holding = 1'b0;
    burst_left = 1;
    clock_ns = 63'd1000;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(psm_pkg::REG_SYNC_WINDOW, 64'(psm_pkg::SYNC_WINDOW_RST));
    write_reg(psm_pkg::REG_BAD_LIMIT, 64'(psm_pkg::BAD_LIMIT_RST));
    write_reg(psm_pkg::REG_STALE_TIMEOUT, 64'(psm_pkg::STALE_TIMEOUT_RST));
    write_reg(REG_SPARE, {$urandom, $urandom});

    send_item(mk(3, 64'd500, 1'b0, 1'b0, 1'b1));
    send_item(mk(1, 64'd0, 1'b1, 1'b1, 1'b0));
    send_item(mk(0, 64'd1000, 1'b1, 1'b0, 1'b0));
    send_item(mk(1, 64'd1500, 1'b1, 1'b0, 1'b0));
    send_item(mk(0, 64'd2000, 1'b1, 1'b0, 1'b0));
    send_item(mk(2, 64'd2100, 1'b1, 1'b0, 1'b0));
    send_item(mk(2, 64'd900000, 1'b1, 1'b0, 1'b0));
    send_item(mk(2, 64'd900000, 1'b1, 1'b0, 1'b0));
    send_item(mk(15, 64'd899000, 1'b1, 1'b1, 1'b0));
    send_item(mk(15, 64'd899500, 1'b1, 1'b0, 1'b0));
    send_item(mk(15, 64'd930000, 1'b1, 1'b0, 1'b0));
    send_item(mk(1, 64'd929999, 1'b1, 1'b0, 1'b1));
    send_item(mk(7, 64'd5000, 1'b0, 1'b1, 1'b0));
    send_item(mk(7, 64'd6000, 1'b0, 1'b0, 1'b1));
    send_item(mk(4, 64'd200000000000, 1'b0, 1'b1, 1'b1));
    send_item(mk(15, 64'(TIME_MAX), 1'b1, 1'b1, 1'b1));
    send_item(mk(14, 64'(TIME_MAX) - 64'd10, 1'b1, 1'b0, 1'b0));
    send_item(mk(14, 64'(TIME_MAX) - 64'd5, 1'b1, 1'b0, 1'b1));
    send_item(mk(13, 64'(TIME_MAX), 1'b0, 1'b0, 1'b0));
    send_item(mk(5, 64'd0, 1'b0, 1'b1, 1'b1));
    run_phase(300);

    drain_results();
    write_reg(psm_pkg::REG_SYNC_WINDOW, 64'd1);
    write_reg(psm_pkg::REG_BAD_LIMIT, 64'd1);
    write_reg(psm_pkg::REG_STALE_TIMEOUT, 64'd1);
    run_phase(330);

    drain_results();
    write_reg(psm_pkg::REG_SYNC_WINDOW, 64'hFFFF_FFFF);
    write_reg(psm_pkg::REG_BAD_LIMIT, 64'd255);
    write_reg(psm_pkg::REG_STALE_TIMEOUT, 64'(TIME_MAX));
    run_phase(330);

    drain_results();
    write_reg(psm_pkg::REG_SYNC_WINDOW, 64'($urandom_range(100, 60000)));
    write_reg(psm_pkg::REG_BAD_LIMIT, 64'($urandom_range(1, 6)));
    write_reg(psm_pkg::REG_STALE_TIMEOUT, 64'($urandom_range(100000, 100000000)));
    write_reg(REG_SPARE, {$urandom, $urandom});
    run_phase(330);

    drain_results();
    write_reg(psm_pkg::REG_SYNC_WINDOW, 64'($urandom_range(1, 32'hFFFF_FFFF)));
    write_reg(psm_pkg::REG_BAD_LIMIT, 64'($urandom_range(1, 255)));
    write_reg(psm_pkg::REG_STALE_TIMEOUT, (64'($urandom) << $urandom_range(0, 30)) | 64'd1);
    run_phase(340);

    drain_results();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
